### rtl/v3n_pkg.sv
// v3n_pkg: shared constants, widths and types for the vector normalizer.
// No dependencies; every other file in rtl/ imports this package.
package v3n_pkg;

  localparam int COMPONENT_WIDTH      = 32;
  localparam int OUTPUT_FRACTION_BITS = 30;

  localparam int FIELD_W   = 32;                  // port field width
  localparam int MAG_W     = COMPONENT_WIDTH;     // magnitude, holds 2^(CW-1)
  localparam int SUM_W     = 2 * COMPONENT_WIDTH; // sum of three squares
  localparam int ROOT_W    = SUM_W / 2;           // one root bit per stage
  localparam int QUO_W     = OUTPUT_FRACTION_BITS + 1;
  localparam int NUM_LANES = 3;
  localparam int FRONT_DEPTH = 4;                 // split, square, add, add
  localparam int PIPE_DEPTH  = FRONT_DEPTH + ROOT_W + QUO_W;

  localparam logic [QUO_W-1:0] UNIT_ONE = {1'b1, {OUTPUT_FRACTION_BITS{1'b0}}};

  typedef struct packed {
    logic [NUM_LANES-1:0][MAG_W-1:0] mag;
    logic [NUM_LANES-1:0]            neg;
    logic                            zero;
  } v3n_aux_t;

endpackage

### rtl/v3n_if.sv
// v3n_if: valid/ready channel interfaces for input and result beats.
// Depends on v3n_pkg for field widths.
interface v3n_in_if;
  import v3n_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] in_x;
  logic signed [FIELD_W-1:0] in_y;
  logic signed [FIELD_W-1:0] in_z;
  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

interface v3n_out_if;
  import v3n_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] unit_x;
  logic signed [FIELD_W-1:0] unit_y;
  logic signed [FIELD_W-1:0] unit_z;
  logic                      was_zero;
  modport source (output valid, output unit_x, output unit_y, output unit_z,
                  output was_zero, input ready);
  modport sink   (input valid, input unit_x, input unit_y, input unit_z,
                  input was_zero, output ready);
endinterface

### rtl/v3n_sqrt.sv
// v3n_sqrt: pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on v3n_pkg; carries the side data of each beat along with it.
module v3n_sqrt (
  input  logic                      clk,
  input  logic                      en,
  input  logic [v3n_pkg::SUM_W-1:0] sum_i,
  input  v3n_pkg::v3n_aux_t         aux_i,
  output logic [v3n_pkg::ROOT_W-1:0] root_o,
  output v3n_pkg::v3n_aux_t         aux_o
);
  import v3n_pkg::*;

  logic [SUM_W-1:0]  rem_r [ROOT_W];
  logic [ROOT_W-1:0] q_r   [ROOT_W];
  v3n_aux_t          aux_r [ROOT_W];

  for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
    localparam int Sh = 2 * (ROOT_W - 1 - g);
    logic [SUM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] q_in;
    v3n_aux_t          aux_in;
    logic [SUM_W+1:0]  trial;
    logic              take;

    if (g == 0) begin : g_first
      assign rem_in = sum_i;
      assign q_in   = '0;
      assign aux_in = aux_i;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign q_in   = q_r[g-1];
      assign aux_in = aux_r[g-1];
    end

    // trial = (4*q + 1) << 2i: the growth of root^2 if this bit is set
    assign trial = (SUM_W+2)'({q_in, 2'b01}) << Sh;
    assign take  = {2'b00, rem_in} >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= take ? (rem_in - trial[SUM_W-1:0]) : rem_in;
        q_r[g]   <= {q_in[ROOT_W-2:0], take};
        aux_r[g] <= aux_in;
      end
    end
  end

  assign root_o = q_r[ROOT_W-1];
  assign aux_o  = aux_r[ROOT_W-1];

endmodule

### rtl/v3n_div_lane.sv
// v3n_div_lane: one restoring-division lane, mag * 2^F / len, one quotient bit per stage.
// Depends on v3n_pkg; the magnitude never exceeds the length, so F+1 bits suffice.
module v3n_div_lane (
  input  logic                       clk,
  input  logic                       en,
  input  logic [v3n_pkg::MAG_W-1:0]  mag_i,
  input  logic [v3n_pkg::ROOT_W-1:0] len_i,
  input  logic                       neg_i,
  output logic [v3n_pkg::QUO_W-1:0]  quo_o,
  output logic                       neg_o
);
  import v3n_pkg::*;

  logic [ROOT_W-1:0] rem_r [QUO_W];
  logic [ROOT_W-1:0] len_r [QUO_W];
  logic [QUO_W-1:0]  q_r   [QUO_W];
  logic              neg_r [QUO_W];

  for (genvar g = 0; g < QUO_W; g++) begin : g_stage
    logic [ROOT_W:0]   part;
    logic [ROOT_W-1:0] len_in;
    logic [QUO_W-1:0]  q_in;
    logic              neg_in;
    logic              take;
    logic [ROOT_W:0]   diff;

    if (g == 0) begin : g_first
      assign part   = (ROOT_W+1)'(mag_i);
      assign len_in = len_i;
      assign q_in   = '0;
      assign neg_in = neg_i;
    end else begin : g_next
      assign part   = {rem_r[g-1], 1'b0};
      assign len_in = len_r[g-1];
      assign q_in   = q_r[g-1];
      assign neg_in = neg_r[g-1];
    end

    assign take = part >= {1'b0, len_in};
    assign diff = part - {1'b0, len_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= take ? diff[ROOT_W-1:0] : part[ROOT_W-1:0];
        len_r[g] <= len_in;
        q_r[g]   <= {q_in[QUO_W-2:0], take};
        neg_r[g] <= neg_in;
      end
    end
  end

  assign quo_o = q_r[QUO_W-1];
  assign neg_o = neg_r[QUO_W-1];

endmodule

### rtl/vector3_normalize.sv
// vector3_normalize: top level, Q16.16 3-vector in, Q2.30 unit vector out.
// Depends on v3n_pkg, v3n_if, v3n_sqrt and v3n_div_lane.
//
//   channel | dir | payload                                 | handshake
//   in_s    | in  | in_x, in_y, in_z (signed Q16.16)        | valid/ready
//   out_m   | out | unit_x/y/z (signed Q2.30), was_zero     | valid/ready
//
// Throughput: one beat per cycle while the output register is not stalled.
// Pipeline: four front stages (split, square, two adds), one stage per root
// bit, one stage per quotient bit, then the output register.
// The root stages and the three divider lanes make up most of the pipe.
// Reset: rst_n (synchronous, active low) clears the valid bits only.
// Stalls: the whole pipe advances together; it holds only when the output
// register is full and not taken. A bubble in the pipe still moves on, so
// the input keeps taking beats while the output register is empty.
module vector3_normalize (
  input  logic clk,
  input  logic rst_n,
  v3n_in_if.sink    in_s,
  v3n_out_if.source out_m
);
  import v3n_pkg::*;

  logic en;
  logic [PIPE_DEPTH-1:0] vld_r;
  logic out_valid_r;

  // Advance the pipe whenever the output register can take a new value.
  assign en         = !out_valid_r || out_m.ready;
  assign in_s.ready = en;

  // Valid bits: shift along with the payload, cleared on reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[PIPE_DEPTH-2:0], in_s.valid};
      out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  // Stage 1: drop the upper field bits, split each component into sign and magnitude.
  logic [FIELD_W-1:0] raw [NUM_LANES];
  assign raw[0] = in_s.in_x;
  assign raw[1] = in_s.in_y;
  assign raw[2] = in_s.in_z;

  v3n_aux_t aux1_nxt, aux1_r, aux2_r, aux3_r, aux4_r;

  always_comb begin
    aux1_nxt = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      aux1_nxt.neg[i] = raw[i][MAG_W-1];
      aux1_nxt.mag[i] = raw[i][MAG_W-1] ? (~raw[i][MAG_W-1:0] + MAG_W'(1))
                                        : raw[i][MAG_W-1:0];
    end
    aux1_nxt.zero = (raw[0][MAG_W-1:0] == '0) && (raw[1][MAG_W-1:0] == '0) &&
                    (raw[2][MAG_W-1:0] == '0);
  end

  // Stage 2: one multiplier per component. Stages 3 and 4: two adds.
  logic [SUM_W-1:0] sq_r [NUM_LANES];
  logic [SUM_W-1:0] sum_ab_r, sq_c_r, sum_r;

  always_ff @(posedge clk) begin
    if (en) begin
      aux1_r <= aux1_nxt;
      for (int i = 0; i < NUM_LANES; i++) begin
        sq_r[i] <= SUM_W'(aux1_r.mag[i]) * SUM_W'(aux1_r.mag[i]);
      end
      aux2_r   <= aux1_r;
      sum_ab_r <= sq_r[0] + sq_r[1];
      sq_c_r   <= sq_r[2];
      aux3_r   <= aux2_r;
      sum_r    <= sum_ab_r + sq_c_r;
      aux4_r   <= aux3_r;
    end
  end

  // Length: truncated integer root of the sum of squares.
  logic [ROOT_W-1:0] len;
  v3n_aux_t          aux_s;

  v3n_sqrt u_sqrt (
    .clk    (clk),
    .en     (en),
    .sum_i  (sum_r),
    .aux_i  (aux4_r),
    .root_o (len),
    .aux_o  (aux_s)
  );

  // Three divider lanes, one per component.
  logic [QUO_W-1:0] quo   [NUM_LANES];
  logic             qneg  [NUM_LANES];

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    v3n_div_lane u_div (
      .clk   (clk),
      .en    (en),
      .mag_i (aux_s.mag[l]),
      .len_i (len),
      .neg_i (aux_s.neg[l]),
      .quo_o (quo[l]),
      .neg_o (qneg[l])
    );
  end

  // Carry the zero flag alongside the divider lanes.
  logic [QUO_W-1:0] zero_r;
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r <= {zero_r[QUO_W-2:0], aux_s.zero};
    end
  end

  // Merge: saturate each quotient to one, restore the sign, force zeros for a
  // zero vector (its length is zero and the lanes then carry garbage).
  logic [FIELD_W-1:0] unit_nxt [NUM_LANES];
  logic [FIELD_W-1:0] unit_r   [NUM_LANES];
  logic               was_zero_r;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      logic [QUO_W-1:0] sat;
      sat = (quo[i] > UNIT_ONE) ? UNIT_ONE : quo[i];
      if (zero_r[QUO_W-1]) begin
        unit_nxt[i] = '0;
      end else if (qneg[i]) begin
        unit_nxt[i] = FIELD_W'(0) - FIELD_W'(sat);
      end else begin
        unit_nxt[i] = FIELD_W'(sat);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_LANES; i++) begin
        unit_r[i] <= unit_nxt[i];
      end
      was_zero_r <= zero_r[QUO_W-1];
    end
  end

  assign out_m.valid    = out_valid_r;
  assign out_m.unit_x   = unit_r[0];
  assign out_m.unit_y   = unit_r[1];
  assign out_m.unit_z   = unit_r[2];
  assign out_m.was_zero = was_zero_r;

endmodule

### rtl/v3n_checker.sv
// v3n_assert_chk: port-level assertions for vector3_normalize, attached by bind.
// Depends on v3n_pkg and on the top level's port names.
module v3n_assert_chk (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [v3n_pkg::FIELD_W-1:0] unit_x,
  input logic signed [v3n_pkg::FIELD_W-1:0] unit_y,
  input logic signed [v3n_pkg::FIELD_W-1:0] unit_z,
  input logic                               was_zero
);
  import v3n_pkg::*;

  localparam logic signed [FIELD_W-1:0] Lim = FIELD_W'(UNIT_ONE);

  // A beat shown but not taken holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(unit_x) && $stable(unit_y) &&
    $stable(unit_z) && $stable(was_zero))
    else $error("output beat changed while stalled");

  // The input side stalls only behind a full, untaken output register.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  // A zero vector gives zero components.
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && was_zero |-> unit_x == '0 && unit_y == '0 && unit_z == '0)
    else $error("zero flag with nonzero components");

  // Every component lies within plus or minus one.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> unit_x <= Lim && unit_x >= -Lim && unit_y <= Lim &&
    unit_y >= -Lim && unit_z <= Lim && unit_z >= -Lim)
    else $error("component beyond unit range");

endmodule

bind vector3_normalize v3n_assert_chk u_v3n_assert_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_s.ready),
  .out_valid (out_m.valid),
  .out_ready (out_m.ready),
  .unit_x    (out_m.unit_x),
  .unit_y    (out_m.unit_y),
  .unit_z    (out_m.unit_z),
  .was_zero  (out_m.was_zero)
);

### sim/v3n_checker.sv
// v3n_checker: watches the vector and unit-vector channels, predicts each unit
// vector from the accepted input beat and compares. Depends on v3n_pkg, v3n_if.
module v3n_checker (
  input  logic         clk,
  input  logic         rst_n,
  v3n_in_if.sink       in_w,
  v3n_out_if.sink      out_w,
  output int           fail_count,
  output int           pending,
  output int           unit_count,
  output int           zero_count,
  output int           sat_count
);
  import v3n_pkg::*;

  typedef struct packed {
    logic [FIELD_W-1:0] ux;
    logic [FIELD_W-1:0] uy;
    logic [FIELD_W-1:0] uz;
    logic               zero;
  } unit_vec_t;

  unit_vec_t unit_q[$];

  function automatic logic [63:0] root_floor(logic [63:0] s);
    logic [63:0] rem, root, b;
    rem = s;
    root = 0;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= root + b) begin
        rem = rem - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic logic [FIELD_W-1:0] scale_lane(logic [63:0] m, logic neg,
                                                    logic [63:0] len, ref int sat);
    logic [63:0] q, one;
    one = 64'd1 << OUTPUT_FRACTION_BITS;
    q = (m << OUTPUT_FRACTION_BITS) / len;
    if (q > one) begin
      q = one;
      sat++;
    end
    if (neg) q = -q;
    return q[FIELD_W-1:0];
  endfunction

  function automatic unit_vec_t normalize(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y,
                                          logic [FIELD_W-1:0] z, ref int sat);
    logic [63:0] raw [3];
    logic [63:0] m [3];
    logic        n [3];
    logic [63:0] cmask, sum, len;
    unit_vec_t   r;
    raw[0] = x; raw[1] = y; raw[2] = z;
    cmask = (COMPONENT_WIDTH == 64) ? '1 : ((64'd1 << COMPONENT_WIDTH) - 1);
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = raw[i] & cmask;
      n[i] = m[i][COMPONENT_WIDTH-1];
      if (n[i]) m[i] = (cmask - m[i]) + 1;
      sum = sum + m[i] * m[i];
    end
    if (sum == 0) begin
      r = '0;
      r.zero = 1'b1;
      return r;
    end
    len = root_floor(sum);
    r.ux = scale_lane(m[0], n[0], len, sat);
    r.uy = scale_lane(m[1], n[1], len, sat);
    r.uz = scale_lane(m[2], n[2], len, sat);
    r.zero = 1'b0;
    return r;
  endfunction

  assign pending = unit_q.size();

  always @(posedge clk) begin
    unit_vec_t e;
    if (!rst_n) begin
      fail_count <= 0;
      unit_count <= 0;
      zero_count <= 0;
      sat_count  <= 0;
    end else begin
      if (in_w.valid && in_w.ready)
        unit_q.push_back(normalize(in_w.in_x, in_w.in_y, in_w.in_z, sat_count));
      if (out_w.valid && out_w.ready) begin
        unit_count <= unit_count + 1;
        if (out_w.was_zero) zero_count <= zero_count + 1;
        if (unit_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("chk: unexpected unit vector beat");
        end else begin
          e = unit_q.pop_front();
          if (e.ux !== out_w.unit_x || e.uy !== out_w.unit_y ||
              e.uz !== out_w.unit_z || e.zero !== out_w.was_zero) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("chk: mismatch exp %h %h %h z%b got %h %h %h z%b",
                       e.ux, e.uy, e.uz, e.zero, out_w.unit_x, out_w.unit_y,
                       out_w.unit_z, out_w.was_zero);
          end
        end
      end
    end
  end
endmodule

### sim/tb.sv
// tb: stimulus and verdict for vector3_normalize; the checker predicts and compares.
// Depends on v3n_pkg, v3n_if, v3n_checker and the RTL.
module tb;
  import v3n_pkg::*;

  localparam int RANDOM_VECS = 800;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk, rst_n;
  int   fail_count, pending, unit_count, zero_count, sat_count;
  longint cycles;
  logic done;

  v3n_in_if  in_c();
  v3n_out_if out_c();

  vector3_normalize u_dut (.clk(clk), .rst_n(rst_n), .in_s(in_c.sink), .out_m(out_c.source));

  v3n_checker u_chk (.clk(clk), .rst_n(rst_n), .in_w(in_c.sink), .out_w(out_c.sink),
                     .fail_count(fail_count), .pending(pending), .unit_count(unit_count),
                     .zero_count(zero_count), .sat_count(sat_count));

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side at random; some stretches run with ready held high.
  initial begin
    int wait_n;
    out_c.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_c.ready && out_c.valid) begin
        wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
        if (wait_n > 0) begin
          out_c.ready <= 1'b0;
          repeat (wait_n) @(posedge clk);
        end
      end
      out_c.ready <= 1'b1;
    end
  end

  // Hold the beat until accepted.
  task automatic send_vec(logic [31:0] x, logic [31:0] y, logic [31:0] z, int gap);
    if (gap > 0) begin
      in_c.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_c.valid <= 1'b1;
    in_c.in_x <= x;
    in_c.in_y <= y;
    in_c.in_z <= z;
    do @(posedge clk); while (!in_c.ready);
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 3) - 2;
      2: return $signed($urandom_range(0, 1 << 17)) - (1 << 16);
      3: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'h0} ^ $urandom_range(0, 7);
      4: return $urandom >> $urandom_range(0, 31);
      default: return -($urandom >> $urandom_range(0, 31));
    endcase
  endfunction

  initial begin
    int gap;
    logic [31:0] dir [$];
    done = 1'b0;
    rst_n = 1'b0;
    in_c.valid = 1'b0;
    in_c.in_x = '0;
    in_c.in_y = '0;
    in_c.in_z = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero vector, axes, extremes, most negative, overshoot cases.
    dir = '{32'h0, 32'h0, 32'h0,
            32'h0001_0000, 32'h0, 32'h0,
            32'h0, 32'hFFFF_0000, 32'h0,
            32'h0, 32'h0, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001,
            32'h1, 32'h1, 32'h1,
            32'h1, 32'h0, 32'h0,
            32'hFFFF_FFFF, 32'h0, 32'h0,
            32'h3, 32'h4, 32'h0,
            32'h2, 32'h3, 32'h0,
            32'h1, 32'h1, 32'h0,
            32'h5555_5555, 32'hAAAA_AAAA, 32'h1234_5678};
    for (int i = 0; i < dir.size(); i += 3)
      send_vec(dir[i], dir[i+1], dir[i+2], $urandom_range(0, 2));

    for (int n = 0; n < RANDOM_VECS; n++) begin
      // Drain once mid-run so the pipe empties completely.
      if (n == RANDOM_VECS / 2) begin
        in_c.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (n % 100 < 20) gap = 0;
      send_vec(rand_comp(), rand_comp(), rand_comp(), gap);
    end
    in_c.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    done = 1'b1;
  end

  initial begin
    cycles = 0;
    while (!done && cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    if (!done) begin
      $display("tb: timeout after %0d cycles, %0d beats pending", cycles, pending);
      $display("tb: FAIL");
    end else begin
      $display("tb: %0d unit vectors checked, %0d zero vectors, %0d saturated lanes",
               unit_count, zero_count, sat_count);
      if (fail_count == 0 && pending == 0) $display("tb: PASS");
      else $display("tb: FAIL");
    end
    $finish;
  end
endmodule
